// File: rtl/core/mbs_pkg.sv
package mbs_pkg;

    // Table sizes and protocol bases
    localparam int COIL_COUNT     = 16;
    localparam int DISCRETE_COUNT = 16;
    localparam int HOLDING_COUNT  = 8;
    localparam int INPUT_COUNT    = 8;
    localparam int COIL_BASE      = 0;
    localparam int DISCRETE_BASE  = 0;
    localparam int MAX_OUT        = 16;

    // Field widths
    localparam int ACT_W  = 3;
    localparam int ADDR_W = 16;
    localparam int CNT_W  = 11;
    localparam int BYTE_W = 8;

    // Derived widths
    localparam int NOUT_W   = $clog2(MAX_OUT);
    localparam int HI_W     = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
    localparam int BITS_MAX = (COIL_COUNT > DISCRETE_COUNT) ? COIL_COUNT : DISCRETE_COUNT;
    localparam int BITS_W   = BITS_MAX + BYTE_W;
    localparam int PB_COIL  = (COIL_COUNT + 7) / 8;
    localparam int PB_HOLD  = 2 * HOLDING_COUNT;
    localparam int PB_MAX   = (PB_COIL > PB_HOLD) ? PB_COIL : PB_HOLD;
    localparam int PB_W     = $clog2(PB_MAX + 1);
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    // Request actions
    localparam logic [ACT_W-1:0] ACT_RD_COIL  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WR_COIL  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RD_DISC  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RD_HOLD  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_WR_HOLD  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_RD_INPUT = 3'd5;
    localparam logic [ACT_W-1:0] ACT_DATA     = 3'd6;

    typedef enum logic [2:0] {
        CMD_STATUS,
        CMD_RD_COIL,
        CMD_RD_DISC,
        CMD_RD_HOLD,
        CMD_RD_INPUT,
        CMD_WR_COIL,
        CMD_WR_HOLD,
        CMD_DATA
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic              status;
        logic              wr_hdr;
        logic [ADDR_W-1:0] off;
        logic [CNT_W-1:0]  cnt;
        logic [BYTE_W-1:0] wbyte;
    } t_cmd;

    function automatic logic [COIL_COUNT-1:0] coil_init();
        logic [15:0]           pat;
        logic [COIL_COUNT-1:0] v;
        pat = 16'h2133;
        for (int i = 0; i < COIL_COUNT; i++) begin
            v[i] = (i < 16) ? pat[i % 16] : 1'b0;
        end
        return v;
    endfunction

    function automatic logic [DISCRETE_COUNT-1:0] disc_init();
        logic [15:0]               pat;
        logic [DISCRETE_COUNT-1:0] v;
        pat = 16'h8866;
        for (int i = 0; i < DISCRETE_COUNT; i++) begin
            v[i] = (i < 16) ? pat[i % 16] : 1'b0;
        end
        return v;
    endfunction

    function automatic logic [15:0] hold_init(input int idx);
        logic [15:0] v;
        if (idx == 0) begin
            v = 16'h0010;
        end else if (idx < 8) begin
            v = 16'(idx * 32'h1111);
        end else begin
            v = 16'h0000;
        end
        return v;
    endfunction

    function automatic logic [15:0] input_init(input logic [ADDR_W-1:0] idx);
        logic [15:0] v;
        case (idx)
            16'd1:   v = 16'h3001;
            16'd2:   v = 16'h2002;
            16'd3:   v = 16'h3003;
            16'd4:   v = 16'h4004;
            16'd5:   v = 16'h5005;
            16'd6:   v = 16'h6006;
            16'd7:   v = 16'h7007;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/mbs_front.sv
module mbs_front
    import mbs_pkg::*;
(
    input  logic              i_valid,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [ADDR_W-1:0] i_start_address,
    input  logic [CNT_W-1:0]  i_item_count,
    input  logic [BYTE_W-1:0] i_write_byte,
    input  logic              i_q_full,
    output logic              o_stall,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [ADDR_W-1:0] first;
    logic [ADDR_W:0]   base;
    logic [ADDR_W:0]   limit;
    logic [ADDR_W:0]   span_end;
    logic              in_rng;
    logic              is_wr;

    assign o_stall = i_q_full;

    always_comb begin
        first = i_start_address - 16'd1;
        case (i_action)
            ACT_RD_COIL, ACT_WR_COIL: begin
                base  = (ADDR_W+1)'(COIL_BASE);
                limit = (ADDR_W+1)'(COIL_BASE + COIL_COUNT);
            end
            ACT_RD_DISC: begin
                base  = (ADDR_W+1)'(DISCRETE_BASE);
                limit = (ADDR_W+1)'(DISCRETE_BASE + DISCRETE_COUNT);
            end
            ACT_RD_HOLD, ACT_WR_HOLD: begin
                base  = '0;
                limit = (ADDR_W+1)'(HOLDING_COUNT);
            end
            default: begin
                base  = '0;
                limit = (ADDR_W+1)'(INPUT_COUNT);
            end
        endcase
        span_end = {1'b0, first} + (ADDR_W+1)'(i_item_count);
        in_rng   = ({1'b0, first} >= base) && (span_end <= limit);
        is_wr    = (i_action == ACT_WR_COIL) || (i_action == ACT_WR_HOLD);

        o_cmd.status = ~in_rng;
        o_cmd.wr_hdr = is_wr;
        o_cmd.off    = first - base[ADDR_W-1:0];
        o_cmd.cnt    = i_item_count;
        o_cmd.wbyte  = i_write_byte;

        if (i_action == ACT_DATA) begin
            o_cmd.kind = CMD_DATA;
        end else if (!in_rng || (i_item_count == '0)) begin
            o_cmd.kind = CMD_STATUS;
        end else begin
            case (i_action)
                ACT_RD_COIL:  o_cmd.kind = CMD_RD_COIL;
                ACT_WR_COIL:  o_cmd.kind = CMD_WR_COIL;
                ACT_RD_DISC:  o_cmd.kind = CMD_RD_DISC;
                ACT_RD_HOLD:  o_cmd.kind = CMD_RD_HOLD;
                ACT_WR_HOLD:  o_cmd.kind = CMD_WR_HOLD;
                default:      o_cmd.kind = CMD_RD_INPUT;
            endcase
        end

        // drop the unused action code here
        o_push = i_valid && !i_q_full && (i_action inside {[ACT_RD_COIL:ACT_DATA]});
    end

endmodule

// File: rtl/core/mbs_queue.sv
module mbs_queue
    import mbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr;
    logic [Q_PTR_W-1:0]  r_rd;
    logic [Q_CNT_W-1:0]  r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("queue fill count beyond depth");

    a_empty_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("empty queue with unequal pointers");

endmodule

// File: rtl/core/mbs_back.sv
module mbs_back
    import mbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_q_empty,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_read_byte,
    output logic              o_status,
    output logic              o_is_data,
    output logic              o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_BITS,
        S_RD_REGS
    } t_state;

    localparam logic [1:0] PK_NONE = 2'd0;
    localparam logic [1:0] PK_COIL = 2'd1;
    localparam logic [1:0] PK_HOLD = 2'd2;

    t_state              r_state,      n_state;
    logic [COIL_COUNT-1:0] r_coil,     n_coil;
    logic [15:0]         r_hold [HOLDING_COUNT];
    logic [15:0]         n_hold [HOLDING_COUNT];
    logic [1:0]          r_kind,       n_kind;
    logic [PB_W-1:0]     r_pend_bytes, n_pend_bytes;
    logic [ADDR_W-1:0]   r_wp,         n_wp;
    logic                r_pend_err,   n_pend_err;
    logic [BYTE_W-1:0]   r_hbl,        n_hbl;
    logic                r_src,        n_src;
    logic [ADDR_W-1:0]   r_ptr,        n_ptr;
    logic                r_half,       n_half;
    logic [CNT_W-1:0]    r_rem,        n_rem;
    logic [NOUT_W-1:0]   r_nout,       n_nout;
    logic                r_out_valid,  n_out_valid;
    logic [BYTE_W-1:0]   r_out_byte,   n_out_byte;
    logic                r_out_status, n_out_status;
    logic                r_out_data,   n_out_data;
    logic                r_out_last,   n_out_last;

    logic                out_free;
    logic                last_byte;
    logic [BITS_W-1:0]   bits_ext;
    logic [BITS_W-1:0]   bits_sh;
    logic [BYTE_W-1:0]   bit_mask;
    logic [15:0]         reg_word;
    logic [BYTE_W-1:0]   nbits;
    logic [ADDR_W-1:0]   wr_ofs;
    logic [CNT_W+2:0]    coil_bytes;

    assign o_valid     = r_out_valid;
    assign o_read_byte = r_out_byte;
    assign o_status    = r_out_status;
    assign o_is_data   = r_out_data;
    assign o_last      = r_out_last;

    always_comb begin
        n_state      = r_state;
        n_coil       = r_coil;
        n_hold       = r_hold;
        n_kind       = r_kind;
        n_pend_bytes = r_pend_bytes;
        n_wp         = r_wp;
        n_pend_err   = r_pend_err;
        n_hbl        = r_hbl;
        n_src        = r_src;
        n_ptr        = r_ptr;
        n_half       = r_half;
        n_rem        = r_rem;
        n_nout       = r_nout;
        n_out_valid  = r_out_valid && i_stall;
        n_out_byte   = r_out_byte;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        last_byte    = 1'b0;
        wr_ofs       = '0;

        out_free = !r_out_valid || !i_stall;

        // bit window from the selected table, zero padded above the top
        bits_ext = r_src ? BITS_W'(disc_init()) : BITS_W'(r_coil);
        bits_sh  = bits_ext >> r_ptr;
        bit_mask = (r_rem >= CNT_W'(BYTE_W)) ? 8'hFF : ~(8'hFF << r_rem[2:0]);

        reg_word = r_src ? input_init(r_ptr) : r_hold[r_ptr[HI_W-1:0]];

        nbits      = (r_pend_bytes == PB_W'(1)) ? r_hbl : 8'd8;
        coil_bytes = ((CNT_W+3)'(i_cmd.cnt) + (CNT_W+3)'(7)) >> 3;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_DATA: begin
                            if (r_kind != PK_NONE) begin
                                if (r_kind == PK_COIL) begin
                                    for (int j = 0; j < COIL_COUNT; j++) begin
                                        wr_ofs = ADDR_W'(j) - r_wp;
                                        if ((ADDR_W'(j) >= r_wp) &&
                                            (wr_ofs < ADDR_W'(nbits))) begin
                                            n_coil[j] = i_cmd.wbyte[wr_ofs[2:0]];
                                        end
                                    end
                                    n_wp = r_wp + ADDR_W'(8);
                                end else if (!r_pend_bytes[0]) begin
                                    n_hbl = i_cmd.wbyte;
                                end else begin
                                    if (r_wp < ADDR_W'(HOLDING_COUNT)) begin
                                        n_hold[r_wp[HI_W-1:0]] = {r_hbl, i_cmd.wbyte};
                                    end
                                    n_wp = r_wp + ADDR_W'(1);
                                end
                                n_pend_bytes = r_pend_bytes - PB_W'(1);
                                if (r_pend_bytes == PB_W'(1)) begin
                                    n_kind       = PK_NONE;
                                    n_out_valid  = 1'b1;
                                    n_out_byte   = '0;
                                    n_out_status = r_pend_err;
                                    n_out_data   = 1'b0;
                                    n_out_last   = 1'b1;
                                end
                            end
                        end
                        CMD_STATUS: begin
                            n_kind       = PK_NONE;
                            n_pend_bytes = '0;
                            if (i_cmd.wr_hdr) begin
                                n_pend_err = i_cmd.status;
                            end
                            n_out_valid  = 1'b1;
                            n_out_byte   = '0;
                            n_out_status = i_cmd.status;
                            n_out_data   = 1'b0;
                            n_out_last   = 1'b1;
                        end
                        CMD_RD_COIL, CMD_RD_DISC: begin
                            n_kind       = PK_NONE;
                            n_pend_bytes = '0;
                            n_src        = (i_cmd.kind == CMD_RD_DISC);
                            n_ptr        = i_cmd.off;
                            n_rem        = i_cmd.cnt;
                            n_nout       = '0;
                            n_state      = S_RD_BITS;
                        end
                        CMD_RD_HOLD, CMD_RD_INPUT: begin
                            n_kind       = PK_NONE;
                            n_pend_bytes = '0;
                            n_src        = (i_cmd.kind == CMD_RD_INPUT);
                            n_ptr        = i_cmd.off;
                            n_rem        = i_cmd.cnt;
                            n_half       = 1'b0;
                            n_nout       = '0;
                            n_state      = S_RD_REGS;
                        end
                        CMD_WR_COIL: begin
                            n_kind       = PK_COIL;
                            n_pend_bytes = coil_bytes[PB_W-1:0];
                            n_wp         = i_cmd.off;
                            n_hbl        = (i_cmd.cnt[2:0] != 3'd0) ?
                                           {5'd0, i_cmd.cnt[2:0]} : 8'd8;
                            n_pend_err   = 1'b0;
                        end
                        CMD_WR_HOLD: begin
                            n_kind       = PK_HOLD;
                            n_pend_bytes = PB_W'({i_cmd.cnt, 1'b0});
                            n_wp         = i_cmd.off;
                            n_pend_err   = 1'b0;
                        end
                        default: begin
                            n_kind = r_kind;
                        end
                    endcase
                end
            end
            S_RD_BITS: begin
                if (out_free) begin
                    last_byte    = (r_rem <= CNT_W'(BYTE_W)) ||
                                   (r_nout == NOUT_W'(MAX_OUT - 1));
                    n_out_valid  = 1'b1;
                    n_out_byte   = bits_sh[BYTE_W-1:0] & bit_mask;
                    n_out_status = 1'b0;
                    n_out_data   = 1'b1;
                    n_out_last   = last_byte;
                    n_ptr        = r_ptr + ADDR_W'(BYTE_W);
                    n_rem        = r_rem - CNT_W'(BYTE_W);
                    n_nout       = r_nout + NOUT_W'(1);
                    if (last_byte) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RD_REGS: begin
                if (out_free) begin
                    last_byte    = (r_half && (r_rem == CNT_W'(1))) ||
                                   (r_nout == NOUT_W'(MAX_OUT - 1));
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_half ? reg_word[7:0] : reg_word[15:8];
                    n_out_status = 1'b0;
                    n_out_data   = 1'b1;
                    n_out_last   = last_byte;
                    n_half       = ~r_half;
                    n_nout       = r_nout + NOUT_W'(1);
                    if (r_half) begin
                        n_ptr = r_ptr + ADDR_W'(1);
                        n_rem = r_rem - CNT_W'(1);
                    end
                    if (last_byte) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_coil       <= coil_init();
            for (int i = 0; i < HOLDING_COUNT; i++) begin
                r_hold[i] <= hold_init(i);
            end
            r_kind       <= PK_NONE;
            r_pend_bytes <= '0;
            r_wp         <= '0;
            r_pend_err   <= 1'b0;
            r_hbl        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_coil       <= n_coil;
            r_hold       <= n_hold;
            r_kind       <= n_kind;
            r_pend_bytes <= n_pend_bytes;
            r_wp         <= n_wp;
            r_pend_err   <= n_pend_err;
            r_hbl        <= n_hbl;
            r_src        <= n_src;
            r_ptr        <= n_ptr;
            r_half       <= n_half;
            r_rem        <= n_rem;
            r_nout       <= n_nout;
            r_out_valid  <= n_out_valid;
            r_out_byte   <= n_out_byte;
            r_out_status <= n_out_status;
            r_out_data   <= n_out_data;
            r_out_last   <= n_out_last;
        end
    end

    a_pend_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind != PK_NONE) |-> (r_pend_bytes != '0))
        else $error("write pending with no bytes left");

    a_read_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_rem != '0))
        else $error("read in progress with nothing left");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_pop)
        else $error("request taken while a read is in progress");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data) |-> (r_out_last && (r_out_byte == '0)))
        else $error("status result without last or with data");

endmodule

// File: rtl/core/modbus_slave_data_model.sv
// Modbus slave register map: coils, discrete inputs, holding registers and
// input registers behind a request stream. A header request carries an
// action, a 1-based start address and a count; the front end subtracts one,
// checks the range against the table and posts a command into a two-entry
// queue, so a new request is taken every cycle while the queue has room.
// The back end drains the queue one command at a time: a status result, a
// write header or a data byte is handled as it is popped; a coil or
// discrete read emits ceil(count/8) bytes, one per cycle while the output
// is not stalled, packed LSB first with the unused top bits of the last
// byte cleared; a register read emits two bytes per register, high byte
// first, one per cycle while not stalled. Reads stop at sixteen bytes, and
// the output register's stall holds everything behind it. A write header
// gives no result; one status result follows its final data byte. A header
// arriving mid-write drops the pending write silently, a data byte with
// nothing pending is dropped, and action code 7 is ignored. Out-of-range
// requests return a single status result with status set.
module modbus_slave_data_model
    import mbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [ADDR_W-1:0] i_start_address,
    input  logic [CNT_W-1:0]  i_item_count,
    input  logic [BYTE_W-1:0] i_write_byte,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_read_byte,
    output logic              o_status,
    output logic              o_is_data,
    output logic              o_last
);

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // classify and range-check each request
    mbs_front u_front (
        .i_valid         (i_valid),
        .i_action        (i_action),
        .i_start_address (i_start_address),
        .i_item_count    (i_item_count),
        .i_write_byte    (i_write_byte),
        .i_q_full        (q_full),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    // decouple request intake from result delivery
    mbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    // hold the tables, run writes and stream read bytes
    mbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_read_byte (o_read_byte),
        .o_status    (o_status),
        .o_is_data   (o_is_data),
        .o_last      (o_last)
    );

endmodule
